// ----- hdl/ekd_pkg.sv -----
// package: word types and key codes for the escape key decoder
`timescale 1ns / 1ps
`default_nettype none

package ekd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_COLS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_ROWS = 1'd1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [9:0] COLS_RESET = 10'd80;
  localparam logic [9:0] ROWS_RESET = 10'd24;
  localparam logic [9:0] POS_MAX    = 10'h3ff;

  // input command codes
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // special bytes
  localparam logic [7:0] BYTE_ESC   = 8'h1b;
  localparam logic [7:0] BYTE_QUIT  = 8'h11;
  localparam logic [7:0] BYTE_LBRK  = 8'h5b;
  localparam logic [7:0] BYTE_TILDE = 8'h7e;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] BYTE_FIVE  = 8'h35;
  localparam logic [7:0] BYTE_SIX   = 8'h36;
  localparam logic [7:0] BYTE_A     = 8'h41;
  localparam logic [7:0] BYTE_B     = 8'h42;
  localparam logic [7:0] BYTE_C     = 8'h43;
  localparam logic [7:0] BYTE_D     = 8'h44;

  // decoded key codes
  localparam logic [8:0] KC_ESC   = 9'd27;
  localparam logic [8:0] KC_QUIT  = 9'd17;
  localparam logic [8:0] KC_LEFT  = 9'd256;
  localparam logic [8:0] KC_RIGHT = 9'd257;
  localparam logic [8:0] KC_UP    = 9'd258;
  localparam logic [8:0] KC_DOWN  = 9'd259;
  localparam logic [8:0] KC_PGUP  = 9'd260;
  localparam logic [8:0] KC_PGDN  = 9'd261;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [8:0] key_code;
    logic [9:0] cursor_col;
    logic [9:0] cursor_row;
    logic       quit;
  } out_word_t;

endpackage

`default_nettype wire

// ----- hdl/escape_key_decoder_cursor.sv -----
// top level: terminal escape sequence decoder with cursor tracking
//
//   port group | dir  | handshake         | word
//   in_*       | in   | in_valid/in_ready | ekd_pkg::in_word_t (cmd, rx_byte)
//   out_*      | out  | out_valid/out_ready| ekd_pkg::out_word_t (key, col, row, quit)
//   cfg_*      | in   | cfg_we only       | index cfg_addr, data cfg_wdata
//
// one input word per cycle while in_ready is high; its key word, if any,
// shows in the output register the cycle after acceptance
// the input is taken while the output register is empty or being drained
// a stalled output word holds the input side only through in_ready
// synchronous active-low reset: parser idle, cursor at 0,0, screen 80x24
`timescale 1ns / 1ps
`default_nettype none

module escape_key_decoder_cursor (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire ekd_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output ekd_pkg::out_word_t                  out_data,
  input  wire                                 cfg_we,
  input  wire [ekd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire [ekd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_SEQ1,
    PH_DIGIT
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               brk_r, brk_nxt;
  logic [7:0]         digit_r, digit_nxt;
  logic [9:0]         col_r, col_nxt;
  logic [9:0]         row_r, row_nxt;
  logic [9:0]         cols_r, rows_r;
  logic               out_valid_r, out_valid_nxt;
  ekd_pkg::out_word_t out_word_r;

  logic       in_fire;
  logic       emit;
  logic [8:0] key;
  logic [7:0] b;
  logic [9:0] last_row;
  logic       can_down;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign b         = in_data.rx_byte;
  assign last_row  = rows_r - 10'd1;
  assign can_down  = (row_r != last_row) && (row_r != ekd_pkg::POS_MAX);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= ekd_pkg::COLS_RESET;
      rows_r <= ekd_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ekd_pkg::CFG_SCREEN_COLS: cols_r <= cfg_wdata;
        ekd_pkg::CFG_SCREEN_ROWS: rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequence parser
  always_comb begin
    emit      = 1'b0;
    key       = ekd_pkg::KC_ESC;
    phase_nxt = phase_r;
    brk_nxt   = brk_r;
    digit_nxt = digit_r;
    if (in_data.cmd == ekd_pkg::CMD_TIMEOUT) begin
      if (phase_r != PH_IDLE) begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (b == ekd_pkg::BYTE_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            emit = 1'b1;
            key  = {1'b0, b};
          end
        end
        PH_ESC: begin
          brk_nxt   = (b == ekd_pkg::BYTE_LBRK);
          phase_nxt = PH_SEQ1;
        end
        PH_SEQ1: begin
          digit_nxt = b;
          phase_nxt = PH_IDLE;
          if (brk_r && b >= ekd_pkg::BYTE_ZERO && b <= ekd_pkg::BYTE_NINE) begin
            phase_nxt = PH_DIGIT;
          end else begin
            emit = 1'b1;
            priority if (brk_r && b == ekd_pkg::BYTE_A) key = ekd_pkg::KC_UP;
            else if (brk_r && b == ekd_pkg::BYTE_B) key = ekd_pkg::KC_DOWN;
            else if (brk_r && b == ekd_pkg::BYTE_C) key = ekd_pkg::KC_RIGHT;
            else if (brk_r && b == ekd_pkg::BYTE_D) key = ekd_pkg::KC_LEFT;
            else key = ekd_pkg::KC_ESC;
          end
        end
        PH_DIGIT: begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
          priority if (b == ekd_pkg::BYTE_TILDE && digit_r == ekd_pkg::BYTE_FIVE)
            key = ekd_pkg::KC_PGUP;
          else if (b == ekd_pkg::BYTE_TILDE && digit_r == ekd_pkg::BYTE_SIX)
            key = ekd_pkg::KC_PGDN;
          else key = ekd_pkg::KC_ESC;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // cursor movement for arrow keys
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (emit) begin
      priority case (key)
        ekd_pkg::KC_LEFT: begin
          if (col_r != 10'd0) begin
            col_nxt = col_r - 10'd1;
          end else if (row_r != 10'd0) begin
            col_nxt = cols_r;
            row_nxt = row_r - 10'd1;
          end
        end
        ekd_pkg::KC_RIGHT: begin
          if (col_r < cols_r) begin
            col_nxt = col_r + 10'd1;
          end else if (can_down) begin
            col_nxt = 10'd0;
            row_nxt = row_r + 10'd1;
          end else begin
            col_nxt = cols_r;
          end
        end
        ekd_pkg::KC_UP: begin
          if (row_r != 10'd0) row_nxt = row_r - 10'd1;
        end
        ekd_pkg::KC_DOWN: begin
          if (can_down) row_nxt = row_r + 10'd1;
        end
        default: ;
      endcase
    end
  end

  // output register occupancy
  always_comb begin
    if (in_fire && emit) out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  // parser and cursor state, output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      brk_r       <= 1'b0;
      digit_r     <= 8'd0;
      col_r       <= 10'd0;
      row_r       <= 10'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        brk_r   <= brk_nxt;
        digit_r <= digit_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_word_r.key_code   <= key;
      out_word_r.cursor_col <= col_nxt;
      out_word_r.cursor_row <= row_nxt;
      out_word_r.quit       <= (key == ekd_pkg::KC_QUIT);
    end
  end

  // quit flag goes only with ctrl-q
  a_quit_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.quit |-> out_word_r.key_code == ekd_pkg::KC_QUIT)
    else $error("quit flag without ctrl-q key");

  // key codes that leave the block never exceed KC_PGDN
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.key_code <= ekd_pkg::KC_PGDN)
    else $error("key code out of range");

  // timeout while idle yields no word
  a_idle_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.cmd == ekd_pkg::CMD_TIMEOUT && phase_r == PH_IDLE
      |=> !out_valid_r)
    else $error("word produced by idle timeout");

  // escape byte while idle starts a sequence
  a_esc_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.cmd == ekd_pkg::CMD_BYTE && phase_r == PH_IDLE
      && in_data.rx_byte == ekd_pkg::BYTE_ESC |=> phase_r == PH_ESC && !out_valid_r)
    else $error("escape byte did not start a sequence");

endmodule

`default_nettype wire
